### design/wag_pkg.sv
// Package for the word alternation graph block.
// Holds the fixed field widths and the controller state type.
// No dependencies; used by every module of the block.
package wag_pkg;

  localparam int SYMBOL_W    = 8;
  localparam int ROW_INDEX_W = 4;
  localparam int BITS_W      = 16;
  localparam int OUT_DATA_W  = 32;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } wag_state_t;

endpackage

### design/wag_lookup.sv
// Letter table of the word alternation graph with its parallel lookup.
// Depends on wag_pkg for the symbol width.
// Rows shift down toward entry 0 while the adjacency rows are read out.
module wag_lookup #(
  parameter int MAX_LETTERS = 16
) (
  input  logic                                   clk,
  input  logic [wag_pkg::SYMBOL_W-1:0]           symbol,
  input  logic [$clog2(MAX_LETTERS+1)-1:0]       count,
  input  logic                                   write_en,
  input  logic [$clog2(MAX_LETTERS)-1:0]         write_idx,
  input  logic                                   shift_en,
  output logic                                   hit,
  output logic [$clog2(MAX_LETTERS)-1:0]         hit_idx,
  output logic [wag_pkg::SYMBOL_W-1:0]           head_letter
);

  localparam int IDX_W = $clog2(MAX_LETTERS);
  localparam int CNT_W = $clog2(MAX_LETTERS + 1);

  logic [wag_pkg::SYMBOL_W-1:0] letters [MAX_LETTERS];

  // Letters are unique in the table, so at most one entry matches.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_LETTERS; i++) begin
      if ((CNT_W'(i) < count) && (letters[i] == symbol)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int r = 0; r < MAX_LETTERS - 1; r++) begin
        letters[r] <= letters[r+1];
      end
    end else if (write_en) begin
      letters[write_idx] <= symbol;
    end
  end

  assign head_letter = letters[0];

endmodule

### design/word_alternation_graph.sv
// Top level of the word alternation graph block.
// Depends on wag_pkg and instantiates wag_lookup for the letter table.
// Tracks letter-pair alternation and reads out the graph at word end.
//
//   Channel  Direction  Beat contents
//   s_*      in         one symbol of the word; tlast marks the final symbol
//   m_*      out        one adjacency row; tlast marks the final row, tuser the overflow flag
//
// Every symbol is absorbed in the cycle it is accepted: the lookup and the update of all
// pair bits run in parallel, so one symbol per cycle is taken while collecting.
// After a final symbol the block drives one row per letter held in the table, one per cycle
// when m_tready allows; s_tready stays low for that whole burst.
// The last row beat clears the word state so the next word starts fresh.
// Reset (rst, synchronous, active high) empties the word state and the output channel.
module word_alternation_graph #(
  parameter int MAX_LETTERS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [wag_pkg::SYMBOL_W-1:0]   s_tdata,   // [7:0] symbol
  input  logic                           s_tlast,   // last_symbol
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [wag_pkg::OUT_DATA_W-1:0] m_tdata,   // [3:0] row_index, [11:4] row_letter,
                                                    // [27:12] neighbour_bits, [31:28] zero
  output logic                           m_tuser,   // [0] overflow
  output logic                           m_tlast    // last_row
);

  localparam int IDX_W = $clog2(MAX_LETTERS);
  localparam int CNT_W = $clog2(MAX_LETTERS + 1);

  wag_pkg::wag_state_t state, state_next;

  logic [CNT_W-1:0]       count, count_next;
  logic                   overflow_seen, overflow_seen_next;
  logic [IDX_W-1:0]       row, row_next;

  // holds is kept symmetric while collecting; turn is only meaningful above the diagonal.
  logic [MAX_LETTERS-1:0] holds [MAX_LETTERS];
  logic [MAX_LETTERS-1:0] holds_next [MAX_LETTERS];
  logic [MAX_LETTERS-1:0] turn [MAX_LETTERS];
  logic [MAX_LETTERS-1:0] turn_next [MAX_LETTERS];

  logic                   in_beat, out_beat, final_row;
  logic                   hit, is_new, apply;
  logic [IDX_W-1:0]       hit_idx, idx;
  logic [wag_pkg::SYMBOL_W-1:0] head_letter;
  logic [MAX_LETTERS-1:0] row_sel;

  assign in_beat   = s_tvalid && s_tready;
  assign out_beat  = m_tvalid && m_tready;
  assign final_row = (CNT_W'(row) + CNT_W'(1)) == count;

  assign is_new = !hit && (count < CNT_W'(MAX_LETTERS));
  assign apply  = in_beat && (hit || is_new);
  assign idx    = hit ? hit_idx : count[IDX_W-1:0];

  wag_lookup #(
    .MAX_LETTERS (MAX_LETTERS)
  ) u_lookup (
    .clk         (clk),
    .symbol      (s_tdata),
    .count       (count),
    .write_en    (in_beat && is_new),
    .write_idx   (count[IDX_W-1:0]),
    .shift_en    (out_beat),
    .hit         (hit),
    .hit_idx     (hit_idx),
    .head_letter (head_letter)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      wag_pkg::ST_COLLECT: begin
        if (in_beat && s_tlast) begin
          state_next = wag_pkg::ST_EMIT;
        end
      end
      wag_pkg::ST_EMIT: begin
        if (out_beat && final_row) begin
          state_next = wag_pkg::ST_COLLECT;
        end
      end
      default: state_next = wag_pkg::ST_COLLECT;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    case (state)
      wag_pkg::ST_COLLECT: s_tready = 1'b1;
      wag_pkg::ST_EMIT:    m_tvalid = 1'b1;
      default: begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
      end
    endcase
  end

  // Word state update. A symbol out of turn breaks the pair; a symbol in
  // turn hands the turn to the other letter. Row readout shifts the holds
  // rows so that the current row always sits at entry 0.
  always_comb begin
    holds_next         = holds;
    turn_next          = turn;
    count_next         = count;
    overflow_seen_next = overflow_seen;
    row_next           = row;
    if (in_beat) begin
      if (is_new) begin
        count_next = count + CNT_W'(1);
      end else if (!hit) begin
        overflow_seen_next = 1'b1;
      end
    end
    if (apply) begin
      for (int a = 0; a < MAX_LETTERS; a++) begin
        for (int b = a + 1; b < MAX_LETTERS; b++) begin
          if (IDX_W'(b) == idx) begin
            if (turn[a][b]) begin
              turn_next[a][b] = 1'b0;
            end else begin
              holds_next[a][b] = 1'b0;
              holds_next[b][a] = 1'b0;
            end
          end else if (IDX_W'(a) == idx) begin
            if (!turn[a][b]) begin
              turn_next[a][b] = 1'b1;
            end else begin
              holds_next[a][b] = 1'b0;
              holds_next[b][a] = 1'b0;
            end
          end
        end
      end
    end
    if (out_beat) begin
      if (final_row) begin
        for (int r = 0; r < MAX_LETTERS; r++) begin
          holds_next[r] = '1;
          turn_next[r]  = '0;
        end
        count_next         = '0;
        overflow_seen_next = 1'b0;
        row_next           = '0;
      end else begin
        for (int r = 0; r < MAX_LETTERS - 1; r++) begin
          holds_next[r] = holds[r+1];
        end
        row_next = row + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= wag_pkg::ST_COLLECT;
      count         <= '0;
      overflow_seen <= 1'b0;
      row           <= '0;
      for (int r = 0; r < MAX_LETTERS; r++) begin
        holds[r] <= '1;
        turn[r]  <= '0;
      end
    end else begin
      state         <= state_next;
      count         <= count_next;
      overflow_seen <= overflow_seen_next;
      row           <= row_next;
      holds         <= holds_next;
      turn          <= turn_next;
    end
  end

  // Neighbours of the current row: assigned letters only, never itself.
  always_comb begin
    for (int j = 0; j < MAX_LETTERS; j++) begin
      row_sel[j] = holds[0][j] && (CNT_W'(j) < count) && (IDX_W'(j) != row);
    end
  end

  assign m_tdata = {4'b0000,
                    wag_pkg::BITS_W'(row_sel),
                    head_letter,
                    wag_pkg::ROW_INDEX_W'(row)};
  assign m_tuser = overflow_seen;
  assign m_tlast = final_row;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for word_alternation_graph.
// Depends on wag_pkg and the RTL of the block; predicts every adjacency row
// from the symbols accepted and compares each output beat field by field.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYMBOL_W    = wag_pkg::SYMBOL_W;
  localparam int ROW_INDEX_W = wag_pkg::ROW_INDEX_W;
  localparam int BITS_W      = wag_pkg::BITS_W;
  localparam int OUT_DATA_W  = wag_pkg::OUT_DATA_W;

  // The block is built with its default capacity.
  localparam int LETTERS = 16;
  localparam int PAD_W = OUT_DATA_W - ROW_INDEX_W - SYMBOL_W - BITS_W;

  // One symbol waiting to be offered on the input stream.
  typedef struct packed {
    logic [SYMBOL_W-1:0] sym;
    logic                fin;
  } sym_item_t;

  // One adjacency row as the block should emit it.
  typedef struct packed {
    logic [ROW_INDEX_W-1:0] idx;
    logic [SYMBOL_W-1:0]    letter;
    logic [BITS_W-1:0]      nbits;
    logic                   ovf;
    logic                   fin;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SYMBOL_W-1:0]   s_tdata = '0;   // [7:0] symbol
  logic                  s_tlast = 1'b0; // last_symbol
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [3:0] row_index, [11:4] row_letter,
                                         // [27:12] neighbour_bits, [31:28] zero
  logic                  m_tuser;        // [0] overflow
  logic                  m_tlast;        // last_row

  word_alternation_graph #(.MAX_LETTERS(LETTERS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Symbols still to be sent and rows still to be received.
  sym_item_t symbol_queue[$];
  row_t      row_expect[$];

  // Shadow copy of the word state, kept by the alternation predictor.
  logic [SYMBOL_W-1:0] letter_tab[LETTERS];
  int unsigned         letter_cnt;
  bit                  pair_ok[LETTERS][LETTERS];
  bit                  pair_turn2[LETTERS][LETTERS];
  bit                  ovf_seen;

  int mismatches = 0;
  int symbols_queued = 0;
  int symbols_sent = 0;
  int words_done = 0;
  int overflow_words = 0;
  int rows_seen = 0;

  task automatic forget_word();
    for (int a = 0; a < LETTERS; a++) begin
      letter_tab[a] = '0;
      for (int b = 0; b < LETTERS; b++) begin
        pair_ok[a][b] = 1'b1;
        pair_turn2[a][b] = 1'b0;
      end
    end
    letter_cnt = 0;
    ovf_seen = 1'b0;
  endtask

  // Folds one accepted symbol into the shadow state. On the final symbol of a
  // word it queues one row per letter held in the table and starts a fresh word.
  task automatic absorb_symbol(input logic [SYMBOL_W-1:0] sym, input logic fin);
    bit          hit;
    int unsigned idx;
    row_t        r;
    hit = 1'b0;
    idx = 0;
    for (int i = 0; i < letter_cnt; i++) begin
      if (!hit && letter_tab[i] == sym) begin
        hit = 1'b1;
        idx = i;
      end
    end
    if (!hit) begin
      if (letter_cnt < LETTERS) begin
        idx = letter_cnt;
        letter_tab[idx] = sym;
        letter_cnt++;
        hit = 1'b1;
      end else begin
        // A new letter with the table full only marks the word.
        ovf_seen = 1'b1;
      end
    end
    if (hit) begin
      // Every pair moves at once, including pairs whose other letter has
      // not shown up yet; a late letter inherits that history.
      for (int x = 0; x < LETTERS; x++) begin
        if (x < idx) begin
          if (pair_turn2[x][idx]) pair_turn2[x][idx] = 1'b0;
          else pair_ok[x][idx] = 1'b0;
        end else if (x > idx) begin
          if (!pair_turn2[idx][x]) pair_turn2[idx][x] = 1'b1;
          else pair_ok[idx][x] = 1'b0;
        end
      end
    end
    if (fin) begin
      for (int i = 0; i < letter_cnt; i++) begin
        r.idx = ROW_INDEX_W'(i);
        r.letter = letter_tab[i];
        r.nbits = '0;
        for (int j = 0; j < letter_cnt; j++) begin
          if (j != i && ((i < j) ? pair_ok[i][j] : pair_ok[j][i])) r.nbits[j] = 1'b1;
        end
        r.ovf = ovf_seen;
        r.fin = (i + 1 == letter_cnt);
        row_expect.push_back(r);
      end
      words_done++;
      if (ovf_seen) overflow_words++;
      forget_word();
    end
  endtask

  task automatic push_sym(input logic [SYMBOL_W-1:0] sym, input logic fin);
    sym_item_t it;
    it.sym = sym;
    it.fin = fin;
    symbol_queue.push_back(it);
    symbols_queued++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("mismatch in %s: expected %h, got %h at %0t", name, want, got, $realtime);
      mismatches++;
    end
  endtask

  // Input driver: offers the queued symbols, with a random pause drawn for
  // every beat. Calm stretches with no pauses come and go at random.
  int  send_gap = 0;
  bit  send_calm = 1'b0;
  sym_item_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_symbol(s_tdata, s_tlast);
        symbols_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (symbol_queue.size() > 0) begin
          next_item = symbol_queue.pop_front();
          s_tdata <= next_item.sym;
          s_tlast <= next_item.fin;
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, 12);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the output side: once a good number of rows has gone by,
  // the receiver refuses rows in the middle of a burst while the driver keeps
  // offering symbols, so the block must stall its input.
  logic hold_off = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_cnt = 0;

  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt <= 0;
    end else if (!hold_done) begin
      if (!hold_off) begin
        if (rows_seen >= 30 && m_tvalid) begin
          hold_off <= 1'b1;
          hold_cnt <= 0;
        end
      end else if (hold_cnt == 199) begin
        hold_off <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end
  end

  // Output monitor: checks each accepted row against the oldest prediction
  // and paces m_tready with its own random stalls.
  int   recv_gap = 0;
  bit   recv_calm = 1'b0;
  row_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        rows_seen <= rows_seen + 1;
        if (row_expect.size() == 0) begin
          if (mismatches < 10)
            $display("row with nothing expected: tdata %h tuser %b tlast %b at %0t",
                     m_tdata, m_tuser, m_tlast, $realtime);
          mismatches++;
        end else begin
          want = row_expect.pop_front();
          check_field("row_index", 32'(want.idx), 32'(m_tdata[3:0]));
          check_field("row_letter", 32'(want.letter), 32'(m_tdata[11:4]));
          check_field("neighbour_bits", 32'(want.nbits), 32'(m_tdata[27:12]));
          check_field("tdata padding", 32'(0), 32'(m_tdata[OUT_DATA_W-1 -: PAD_W]));
          check_field("overflow", 32'(want.ovf), 32'(m_tuser));
          check_field("last_row", 32'(want.fin), 32'(m_tlast));
        end
        if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
        recv_gap = recv_calm ? 0 : $urandom_range(0, 12);
      end
      if (hold_off) begin
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int kind;
    int len;
    int k;
    int bad_pos;
    int big_words;
    logic [SYMBOL_W-1:0] alpha[5];
    logic [SYMBOL_W-1:0] s;

    forget_word();
    big_words = 0;

    // Two letters, the zero byte and the all-ones byte, that keep alternating.
    push_sym(8'h00, 1'b0);
    push_sym(8'hFF, 1'b0);
    push_sym(8'h00, 1'b0);
    push_sym(8'hFF, 1'b1);
    // A word of a single letter: one row with no neighbours.
    push_sym(8'hA5, 1'b1);
    // A repeated letter breaks the only pair.
    push_sym(8'h3C, 1'b0);
    push_sym(8'hC3, 1'b0);
    push_sym(8'hC3, 1'b1);
    // Sixteen distinct letters fill the table; a new one on the last symbol
    // overflows it. Every pair still alternates.
    for (int j = 0; j < LETTERS; j++) push_sym(SYMBOL_W'(j * 17), 1'b0);
    push_sym(8'h5A, 1'b1);

    // Random words. Most repeat a small set of letters in turn, some with one
    // symbol spoiled; the rest draw from a tiny alphabet or from all bytes, and
    // a couple are wide enough to overflow the table.
    while (symbols_queued < 120) begin
      kind = $urandom_range(0, 9);
      for (int j = 0; j < 5; j++) alpha[j] = SYMBOL_W'($urandom_range(0, 255));
      if (kind == 9 && big_words < 2) begin
        big_words++;
        len = $urandom_range(17, 20);
        for (int j = 0; j < len; j++)
          push_sym(alpha[0] + SYMBOL_W'(j * 13), j == len - 1);
      end else if (kind <= 6) begin
        k = $urandom_range(2, 5);
        len = $urandom_range(1, 14);
        bad_pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int j = 0; j < len; j++) begin
          s = (j == bad_pos) ? alpha[$urandom_range(0, k - 1)] : alpha[j % k];
          push_sym(s, j == len - 1);
        end
      end else if (kind == 7) begin
        len = $urandom_range(1, 10);
        for (int j = 0; j < len; j++) push_sym(alpha[$urandom_range(0, 3)], j == len - 1);
      end else begin
        len = $urandom_range(1, 8);
        for (int j = 0; j < len; j++)
          push_sym(SYMBOL_W'($urandom_range(0, 255)), j == len - 1);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (symbol_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (row_expect.size() != 0) @(posedge clk);
    // Run on past the last expected row so that a stray row would still be caught.
    repeat (20) @(posedge clk);

    $display("Sent %0d symbols in %0d words, %0d of them past capacity.",
             symbols_sent, words_done, overflow_words);
    $display("Checked %0d adjacency rows, %0d mismatches.", rows_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("timeout with %0d rows still expected", row_expect.size());
    $display("tb: failure");
    $finish;
  end

endmodule
